[rtl/sdspi_pkg.sv]
// Shared types and constants for the SD card SPI host engine.
// No dependencies.
`timescale 1ns / 1ps
package sdspi_pkg;

  typedef enum logic [4:0] {
    PH_IDLE, PH_INIT_DUMMY, PH_CMD, PH_STUFF, PH_POLL, PH_AFTER_IDLE, PH_SKIP_IF,
    PH_RETRY_OP, PH_AFTER_OP, PH_OCR, PH_SKIP_OCR, PH_FINAL, PH_READY_CMD,
    PH_READY_STOP, PH_READY_BLOCK, PH_READY_END, PH_TOKEN, PH_RD_DATA, PH_RD_CRC,
    PH_WR_TOKEN, PH_WR_NEED, PH_WR_DATA, PH_WR_CRC, PH_WR_RESP, PH_WR_STOP, PH_PAD
  } sdspi_phase_e;

  typedef enum logic [1:0] {
    ACT_REQUEST = 2'd0, ACT_RX = 2'd1, ACT_WDATA = 2'd2, ACT_NONE = 2'd3
  } sdspi_action_e;

  localparam logic [1:0] CFG_ATTEMPTS   = 2'd0;
  localparam logic [1:0] CFG_IDLE_LIMIT = 2'd1;
  localparam logic [1:0] CFG_POLLS      = 2'd2;

  localparam logic [1:0] KIND_TX   = 2'd0;
  localparam logic [1:0] KIND_RD   = 2'd1;
  localparam logic [1:0] KIND_NEED = 2'd2;
  localparam logic [1:0] KIND_DONE = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_IDLE_TO   = 3'd1;
  localparam logic [2:0] ST_READY_TO  = 3'd2;
  localparam logic [2:0] ST_CMD_REJ   = 3'd3;
  localparam logic [2:0] ST_DATA_REJ  = 3'd4;

  localparam logic [2:0] OP_INIT     = 3'd0;
  localparam logic [2:0] OP_RD_ONE   = 3'd1;
  localparam logic [2:0] OP_WR_ONE   = 3'd2;
  localparam logic [2:0] OP_RD_MANY  = 3'd3;
  localparam logic [2:0] OP_WR_MANY  = 3'd4;

  localparam logic [7:0] C_GO_IDLE  = 8'h40;
  localparam logic [7:0] C_OP_COND  = 8'h41;
  localparam logic [7:0] C_IF_COND  = 8'h48;
  localparam logic [7:0] C_STOP     = 8'h4C;
  localparam logic [7:0] C_RD_ONE   = 8'h51;
  localparam logic [7:0] C_RD_MANY  = 8'h52;
  localparam logic [7:0] C_WR_ONE   = 8'h58;
  localparam logic [7:0] C_WR_MANY  = 8'h59;
  localparam logic [7:0] C_READ_OCR = 8'h7A;

  localparam logic [7:0] TOK_START  = 8'hFE;
  localparam logic [7:0] TOK_MULTI  = 8'hFC;
  localparam logic [7:0] TOK_STOP   = 8'hFD;
  localparam logic [7:0] BYTE_IDLE  = 8'hFF;
  localparam logic [7:0] CRC_GO_IDLE = 8'h95;
  localparam logic [7:0] CRC_IF_COND = 8'h87;
  localparam logic [7:0] DRESP_OK   = 8'h05;

  localparam int unsigned DUMMY_BYTES = 15;

  typedef struct packed {
    sdspi_phase_e phase;
    logic [12:0]  poll;
    logic [3:0]   attempt;
    logic [8:0]   blocks_left;
    logic [31:0]  addr;
    logic         blk_addr;
    logic         v2;
    logic         fast;
    logic [2:0]   seq_op;
    logic [7:0]   cmd;
    logic [4:0]   polls_done;
  } eng_state_t;

  typedef struct packed {
    logic [3:0]  init_attempts;
    logic [11:0] idle_poll_limit;
    logic [3:0]  response_polls;
  } cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tx;
    logic       cs;
    logic [7:0] rd;
    logic [2:0] st;
    logic [7:0] r1;
    logic       fast;
  } res_t;

  typedef struct packed {
    res_t res;
    logic last;
  } beat_t;

endpackage

[rtl/sd_card_spi_host_engine_core.sv]
// Top level of the SD card SPI host engine: state, configuration, step, queue.
// Depends on sdspi_pkg, sdspi_step and sdspi_out_fifo.
//
// Usage: the input channel carries requests, bytes returned from the card and
// write data bytes; each accepted beat makes zero, one or two result beats on
// the output channel (transmit byte, read data byte, write data request, done).
// One input beat is taken per cycle while in_ready_o is high: the step logic
// between the state registers and the four-entry result queue finishes each
// beat in that cycle. Results are registered in the queue before they reach the
// output. in_ready_o stays high while the queue has room for two results, so
// beats that make two results can fill it faster than the receiver drains it.
// When the receiver stalls, results wait in the queue and input is held off
// once fewer than two slots are free; nothing is dropped.
// Reset puts the engine idle with slow clock and byte addressing and loads the
// configuration defaults; configuration writes take effect on the next cycle.
`timescale 1ns / 1ps
module sd_card_spi_host_engine_core #(
  parameter int unsigned BLOCK_BYTES = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [11:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [2:0]  op_i,
  input  logic [31:0] block_addr_i,
  input  logic [7:0]  block_count_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [7:0]  wr_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  tx_byte_o,
  output logic        cs_active_o,
  output logic [7:0]  rd_data_o,
  output logic [2:0]  status_o,
  output logic [7:0]  r1_value_o,
  output logic        fast_clock_o,
  output logic        last_o
);

  localparam int unsigned BCW = $clog2(BLOCK_BYTES + 1);

  sdspi_pkg::eng_state_t st_q, st_d;
  logic [BCW-1:0]        bc_q, bc_d;
  sdspi_pkg::cfg_t       cfg_q;
  sdspi_pkg::res_t       res0, res1;
  logic [1:0]            nres;
  logic                  accept;
  logic                  room2;
  logic [1:0]            push_n;
  sdspi_pkg::beat_t      push0, push1, head;

  assign in_ready_o = room2;
  assign accept = in_valid_i && room2;

  sdspi_step #(.BLOCK_BYTES(BLOCK_BYTES), .BCW(BCW)) u_step (
    .st_i(st_q), .bc_i(bc_q), .cfg_i(cfg_q),
    .action_i(action_i), .op_i(op_i), .block_addr_i(block_addr_i),
    .block_count_i(block_count_i), .rx_byte_i(rx_byte_i), .wr_data_i(wr_data_i),
    .st_o(st_d), .bc_o(bc_d), .res0_o(res0), .res1_o(res1), .nres_o(nres)
  );

  assign push_n = accept ? nres : 2'd0;
  assign push0 = '{res: res0, last: (nres == 2'd1)};
  assign push1 = '{res: res1, last: 1'b1};

  sdspi_out_fifo u_fifo (
    .clk_i(clk_i), .rst_ni(rst_ni), .push_n_i(push_n), .push0_i(push0),
    .push1_i(push1), .room2_o(room2), .valid_o(out_valid_o),
    .ready_i(out_ready_i), .data_o(head)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{phase: sdspi_pkg::PH_IDLE, default: '0};
      bc_q <= '0;
      cfg_q <= '{init_attempts: 4'd10, idle_poll_limit: 12'd1000, response_polls: 4'd10};
    end else begin
      if (accept) begin
        st_q <= st_d;
        bc_q <= bc_d;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sdspi_pkg::CFG_ATTEMPTS: cfg_q.init_attempts <= cfg_data_i[3:0];
          sdspi_pkg::CFG_IDLE_LIMIT: cfg_q.idle_poll_limit <= cfg_data_i;
          sdspi_pkg::CFG_POLLS: cfg_q.response_polls <= cfg_data_i[3:0];
          default: ;
        endcase
      end
    end
  end

  assign kind_o = head.res.kind;
  assign tx_byte_o = head.res.tx;
  assign cs_active_o = head.res.cs;
  assign rd_data_o = head.res.rd;
  assign status_o = head.res.st;
  assign r1_value_o = head.res.r1;
  assign fast_clock_o = head.res.fast;
  assign last_o = head.last;

endmodule

[rtl/sdspi_step.sv]
// Combinational step of the protocol engine: next state and up to two results.
// Depends on sdspi_pkg.
`timescale 1ns / 1ps
module sdspi_step #(
  parameter int unsigned BLOCK_BYTES = 512,
  parameter int unsigned BCW = 10
) (
  input  sdspi_pkg::eng_state_t st_i,
  input  logic [BCW-1:0]        bc_i,
  input  sdspi_pkg::cfg_t       cfg_i,
  input  logic [1:0]            action_i,
  input  logic [2:0]            op_i,
  input  logic [31:0]           block_addr_i,
  input  logic [7:0]            block_count_i,
  input  logic [7:0]            rx_byte_i,
  input  logic [7:0]            wr_data_i,
  output sdspi_pkg::eng_state_t st_o,
  output logic [BCW-1:0]        bc_o,
  output sdspi_pkg::res_t       res0_o,
  output sdspi_pkg::res_t       res1_o,
  output logic [1:0]            nres_o
);

  function automatic logic [7:0] frame_byte(logic [2:0] i, logic [7:0] cmd,
                                            logic [31:0] arg);
    logic [7:0] b;
    case (i)
      3'd0: b = cmd;
      3'd1: b = arg[31:24];
      3'd2: b = arg[23:16];
      3'd3: b = arg[15:8];
      3'd4: b = arg[7:0];
      default: begin
        if (cmd == sdspi_pkg::C_GO_IDLE) b = sdspi_pkg::CRC_GO_IDLE;
        else if (cmd == sdspi_pkg::C_IF_COND) b = sdspi_pkg::CRC_IF_COND;
        else b = sdspi_pkg::BYTE_IDLE;
      end
    endcase
    return b;
  endfunction

  sdspi_pkg::eng_state_t s;
  logic [BCW-1:0] bc;
  logic           has_rd;
  logic           m_valid;
  logic [1:0]     m_kind;
  logic [7:0]     m_tx;
  logic [2:0]     m_st;
  logic [7:0]     m_r1;
  logic           do_start;
  logic [7:0]     start_code;
  logic [31:0]    start_arg;
  logic           do_fail;
  logic [2:0]     fail_st;
  logic           do_attempt;
  logic [4:0]     lim;
  logic [31:0]    scaled;
  logic [7:0]     rx;
  sdspi_pkg::res_t m_res;
  sdspi_pkg::res_t rd_res;

  assign rx = rx_byte_i;
  assign scaled = 32'(block_addr_i * 32'(BLOCK_BYTES));
  assign lim = (cfg_i.response_polls == 4'd0) ? 5'd16 : {1'b0, cfg_i.response_polls};

  always_comb begin
    s = st_i;
    bc = bc_i;
    has_rd = 1'b0;
    m_valid = 1'b0;
    m_kind = sdspi_pkg::KIND_TX;
    m_tx = sdspi_pkg::BYTE_IDLE;
    m_st = sdspi_pkg::ST_OK;
    m_r1 = 8'd0;
    do_start = 1'b0;
    start_code = 8'd0;
    start_arg = 32'd0;
    do_fail = 1'b0;
    fail_st = sdspi_pkg::ST_OK;
    do_attempt = 1'b0;
    case (action_i)
      sdspi_pkg::ACT_REQUEST: begin
        if (st_i.phase == sdspi_pkg::PH_IDLE) begin
          m_valid = 1'b1;
          if (op_i == sdspi_pkg::OP_INIT) begin
            s.seq_op = sdspi_pkg::OP_INIT;
            s.attempt = 4'd0;
            if (cfg_i.init_attempts == 4'd0) begin
              m_kind = sdspi_pkg::KIND_DONE;
              m_st = sdspi_pkg::ST_IDLE_TO;
            end else begin
              do_attempt = 1'b1;
            end
          end else if (op_i > sdspi_pkg::OP_WR_MANY) begin
            m_kind = sdspi_pkg::KIND_DONE;
            m_st = sdspi_pkg::ST_CMD_REJ;
          end else begin
            s.seq_op = op_i;
            s.addr = st_i.blk_addr ? block_addr_i : scaled;
            if (op_i == sdspi_pkg::OP_RD_MANY || op_i == sdspi_pkg::OP_WR_MANY)
              s.blocks_left = (block_count_i == 8'd0) ? 9'd256 : {1'b0, block_count_i};
            else
              s.blocks_left = 9'd1;
            s.phase = sdspi_pkg::PH_READY_CMD;
          end
        end
      end
      sdspi_pkg::ACT_WDATA: begin
        if (st_i.phase == sdspi_pkg::PH_WR_NEED) begin
          m_valid = 1'b1;
          m_tx = wr_data_i;
          s.phase = sdspi_pkg::PH_WR_DATA;
        end
      end
      sdspi_pkg::ACT_RX: begin
        m_valid = 1'b1;
        case (st_i.phase)
          sdspi_pkg::PH_INIT_DUMMY: begin
            bc = bc_i + BCW'(1);
            if (bc >= BCW'(sdspi_pkg::DUMMY_BYTES)) begin
              s.poll = 13'd0;
              do_start = 1'b1;
              start_code = sdspi_pkg::C_GO_IDLE;
            end
          end
          sdspi_pkg::PH_CMD: begin
            bc = bc_i + BCW'(1);
            if (bc < BCW'(6)) begin
              m_tx = frame_byte(bc[2:0], st_i.cmd, st_i.addr);
            end else if (st_i.cmd == sdspi_pkg::C_STOP) begin
              s.phase = sdspi_pkg::PH_STUFF;
            end else begin
              s.polls_done = 5'd0;
              s.phase = sdspi_pkg::PH_POLL;
            end
          end
          sdspi_pkg::PH_STUFF: begin
            s.polls_done = 5'd0;
            s.phase = sdspi_pkg::PH_POLL;
          end
          sdspi_pkg::PH_POLL: begin
            s.polls_done = st_i.polls_done + 5'd1;
            if (!(rx[7] && s.polls_done < lim)) begin
              case (st_i.cmd)
                sdspi_pkg::C_GO_IDLE: begin
                  if (rx == 8'd1) begin
                    s.phase = sdspi_pkg::PH_AFTER_IDLE;
                  end else if (st_i.poll > {1'b0, cfg_i.idle_poll_limit}) begin
                    m_valid = 1'b0;
                    do_fail = 1'b1;
                    fail_st = sdspi_pkg::ST_IDLE_TO;
                  end else begin
                    s.poll = st_i.poll + 13'd1;
                    do_start = 1'b1;
                    start_code = sdspi_pkg::C_GO_IDLE;
                  end
                end
                sdspi_pkg::C_IF_COND: begin
                  s.v2 = (rx == 8'd1);
                  if (s.v2) begin
                    bc = BCW'(5);
                  end else begin
                    bc = BCW'(1);
                    s.blk_addr = 1'b0;
                  end
                  s.phase = sdspi_pkg::PH_SKIP_IF;
                end
                sdspi_pkg::C_OP_COND:
                  s.phase = (rx == 8'd0) ? sdspi_pkg::PH_AFTER_OP : sdspi_pkg::PH_RETRY_OP;
                sdspi_pkg::C_READ_OCR:
                  s.phase = (rx == 8'd0) ? sdspi_pkg::PH_OCR : sdspi_pkg::PH_FINAL;
                sdspi_pkg::C_RD_ONE, sdspi_pkg::C_RD_MANY: begin
                  if (rx != 8'd0) begin
                    m_kind = sdspi_pkg::KIND_DONE;
                    m_st = sdspi_pkg::ST_CMD_REJ;
                    m_r1 = rx;
                  end else begin
                    s.phase = sdspi_pkg::PH_TOKEN;
                  end
                end
                sdspi_pkg::C_WR_ONE: begin
                  if (rx != 8'd0) begin
                    m_kind = sdspi_pkg::KIND_DONE;
                    m_st = sdspi_pkg::ST_CMD_REJ;
                    m_r1 = rx;
                  end else begin
                    s.phase = sdspi_pkg::PH_WR_TOKEN;
                    m_tx = sdspi_pkg::TOK_START;
                  end
                end
                sdspi_pkg::C_WR_MANY: begin
                  if (rx > 8'd1) begin
                    m_kind = sdspi_pkg::KIND_DONE;
                    m_st = sdspi_pkg::ST_CMD_REJ;
                    m_r1 = rx;
                  end else begin
                    s.phase = sdspi_pkg::PH_READY_BLOCK;
                  end
                end
                default: s.phase = sdspi_pkg::PH_PAD;
              endcase
            end
          end
          sdspi_pkg::PH_AFTER_IDLE: begin
            do_start = 1'b1;
            start_code = sdspi_pkg::C_IF_COND;
            start_arg = 32'h0000_01AA;
          end
          sdspi_pkg::PH_SKIP_IF: begin
            if (bc_i != '0) bc = bc_i - BCW'(1);
            if (bc == '0) begin
              s.poll = 13'd0;
              do_start = 1'b1;
              start_code = sdspi_pkg::C_OP_COND;
              start_arg = st_i.v2 ? 32'h4000_0000 : 32'd0;
            end
          end
          sdspi_pkg::PH_RETRY_OP: begin
            if (st_i.poll > {1'b0, cfg_i.idle_poll_limit}) begin
              m_valid = 1'b0;
              do_fail = 1'b1;
              fail_st = sdspi_pkg::ST_READY_TO;
            end else begin
              s.poll = st_i.poll + 13'd1;
              do_start = 1'b1;
              start_code = sdspi_pkg::C_OP_COND;
              start_arg = st_i.addr;
            end
          end
          sdspi_pkg::PH_AFTER_OP: begin
            if (st_i.v2) begin
              do_start = 1'b1;
              start_code = sdspi_pkg::C_READ_OCR;
            end else begin
              s.phase = sdspi_pkg::PH_FINAL;
            end
          end
          sdspi_pkg::PH_OCR: begin
            s.blk_addr = rx[6];
            bc = BCW'(4);
            s.phase = sdspi_pkg::PH_SKIP_OCR;
          end
          sdspi_pkg::PH_SKIP_OCR: begin
            if (bc_i != '0) bc = bc_i - BCW'(1);
            s.phase = (bc != '0) ? sdspi_pkg::PH_SKIP_OCR : sdspi_pkg::PH_FINAL;
          end
          sdspi_pkg::PH_FINAL: begin
            s.fast = 1'b1;
            m_kind = sdspi_pkg::KIND_DONE;
          end
          sdspi_pkg::PH_READY_CMD: begin
            if (rx != 8'd0) begin
              do_start = 1'b1;
              start_arg = st_i.addr;
              case (st_i.seq_op)
                sdspi_pkg::OP_RD_ONE:  start_code = sdspi_pkg::C_RD_ONE;
                sdspi_pkg::OP_WR_ONE:  start_code = sdspi_pkg::C_WR_ONE;
                sdspi_pkg::OP_RD_MANY: start_code = sdspi_pkg::C_RD_MANY;
                default:               start_code = sdspi_pkg::C_WR_MANY;
              endcase
            end
          end
          sdspi_pkg::PH_READY_STOP: begin
            if (rx != 8'd0) begin
              do_start = 1'b1;
              start_code = sdspi_pkg::C_STOP;
            end
          end
          sdspi_pkg::PH_READY_BLOCK: begin
            if (rx != 8'd0) begin
              s.phase = sdspi_pkg::PH_WR_TOKEN;
              m_tx = sdspi_pkg::TOK_MULTI;
            end
          end
          sdspi_pkg::PH_READY_END: begin
            if (rx != 8'd0) begin
              s.phase = sdspi_pkg::PH_WR_STOP;
              m_tx = sdspi_pkg::TOK_STOP;
            end
          end
          sdspi_pkg::PH_TOKEN: begin
            if (rx == sdspi_pkg::TOK_START) begin
              bc = '0;
              s.phase = sdspi_pkg::PH_RD_DATA;
            end
          end
          sdspi_pkg::PH_RD_DATA: begin
            has_rd = 1'b1;
            bc = bc_i + BCW'(1);
            if (bc >= BCW'(BLOCK_BYTES)) begin
              bc = '0;
              s.phase = sdspi_pkg::PH_RD_CRC;
            end
          end
          sdspi_pkg::PH_RD_CRC: begin
            bc = bc_i + BCW'(1);
            if (bc >= BCW'(2)) begin
              if (st_i.blocks_left != 9'd0) s.blocks_left = st_i.blocks_left - 9'd1;
              if (s.blocks_left != 9'd0) s.phase = sdspi_pkg::PH_TOKEN;
              else if (st_i.seq_op == sdspi_pkg::OP_RD_MANY)
                s.phase = sdspi_pkg::PH_READY_STOP;
              else m_kind = sdspi_pkg::KIND_DONE;
            end
          end
          sdspi_pkg::PH_WR_TOKEN: begin
            bc = '0;
            m_kind = sdspi_pkg::KIND_NEED;
            s.phase = sdspi_pkg::PH_WR_NEED;
          end
          sdspi_pkg::PH_WR_DATA: begin
            bc = bc_i + BCW'(1);
            if (bc < BCW'(BLOCK_BYTES)) begin
              m_kind = sdspi_pkg::KIND_NEED;
              s.phase = sdspi_pkg::PH_WR_NEED;
            end else begin
              bc = '0;
              s.phase = sdspi_pkg::PH_WR_CRC;
            end
          end
          sdspi_pkg::PH_WR_CRC: begin
            bc = bc_i + BCW'(1);
            s.phase = (bc < BCW'(2)) ? sdspi_pkg::PH_WR_CRC : sdspi_pkg::PH_WR_RESP;
          end
          sdspi_pkg::PH_WR_RESP: begin
            if (rx[4:0] != sdspi_pkg::DRESP_OK[4:0]) begin
              m_kind = sdspi_pkg::KIND_DONE;
              m_st = sdspi_pkg::ST_DATA_REJ;
            end else begin
              if (st_i.blocks_left != 9'd0) s.blocks_left = st_i.blocks_left - 9'd1;
              if (s.blocks_left != 9'd0) s.phase = sdspi_pkg::PH_READY_BLOCK;
              else if (st_i.seq_op == sdspi_pkg::OP_WR_MANY)
                s.phase = sdspi_pkg::PH_READY_END;
              else m_kind = sdspi_pkg::KIND_DONE;
            end
          end
          sdspi_pkg::PH_WR_STOP: s.phase = sdspi_pkg::PH_PAD;
          sdspi_pkg::PH_PAD: m_kind = sdspi_pkg::KIND_DONE;
          default: m_valid = 1'b0;
        endcase
      end
      default: ;
    endcase

    if (do_fail) begin
      m_valid = 1'b1;
      if (s.attempt != 4'd15) s.attempt = s.attempt + 4'd1;
      if (s.attempt >= cfg_i.init_attempts) begin
        m_kind = sdspi_pkg::KIND_DONE;
        m_st = fail_st;
      end else begin
        do_attempt = 1'b1;
      end
    end
    if (do_attempt) begin
      s.fast = 1'b0;
      bc = '0;
      s.phase = sdspi_pkg::PH_INIT_DUMMY;
      m_kind = sdspi_pkg::KIND_TX;
      m_tx = sdspi_pkg::BYTE_IDLE;
    end
    if (do_start) begin
      s.cmd = start_code;
      s.addr = start_arg;
      bc = '0;
      s.phase = sdspi_pkg::PH_CMD;
      m_kind = sdspi_pkg::KIND_TX;
      m_tx = start_code;
    end
    if (m_kind == sdspi_pkg::KIND_DONE) s.phase = sdspi_pkg::PH_IDLE;
  end

  always_comb begin
    m_res = '0;
    m_res.kind = m_kind;
    m_res.fast = s.fast;
    case (m_kind)
      sdspi_pkg::KIND_TX: begin
        m_res.tx = m_tx;
        m_res.cs = (s.phase != sdspi_pkg::PH_INIT_DUMMY);
      end
      sdspi_pkg::KIND_DONE: begin
        m_res.st = m_st;
        m_res.r1 = m_r1;
      end
      default: ;
    endcase
    rd_res = '0;
    rd_res.kind = sdspi_pkg::KIND_RD;
    rd_res.rd = rx;
    rd_res.fast = s.fast;
  end

  assign st_o = s;
  assign bc_o = bc;
  assign res0_o = has_rd ? rd_res : m_res;
  assign res1_o = m_res;
  assign nres_o = {1'b0, m_valid} + {1'b0, has_rd};

endmodule

[rtl/sdspi_out_fifo.sv]
// Four-entry result queue taking up to two beats per cycle.
// Depends on sdspi_pkg.
`timescale 1ns / 1ps
module sdspi_out_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          push_n_i,
  input  sdspi_pkg::beat_t    push0_i,
  input  sdspi_pkg::beat_t    push1_i,
  output logic                room2_o,
  output logic                valid_o,
  input  logic                ready_i,
  output sdspi_pkg::beat_t    data_o
);

  sdspi_pkg::beat_t mem_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;
  logic       pop;

  assign valid_o = (cnt_q != 3'd0);
  assign pop = valid_o && ready_i;
  assign room2_o = (cnt_q <= 3'd2);
  assign data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) mem_q[wr_q] <= push0_i;
    if (push_n_i == 2'd2) mem_q[wr_q + 2'd1] <= push1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 2'd0;
      rd_q <= 2'd0;
      cnt_q <= 3'd0;
    end else begin
      wr_q <= wr_q + push_n_i;
      rd_q <= rd_q + {1'b0, pop};
      cnt_q <= cnt_q + {1'b0, push_n_i} - {2'b0, pop};
    end
  end

endmodule

[rtl/sdspi_checker.sv]
// Port-level checks on the engine's result channel, bound to the top level.
// Depends on sd_card_spi_host_engine_core port names and sdspi_pkg.
`timescale 1ns / 1ps
module sdspi_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] kind_o,
  input logic       cs_active_o,
  input logic [7:0] rd_data_o,
  input logic [2:0] status_o,
  input logic [7:0] tx_byte_o
);

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result beat during reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) && $stable(tx_byte_o))
    else $error("stalled result beat changed");

  a_cs_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cs_active_o |-> kind_o == sdspi_pkg::KIND_TX)
    else $error("chip select on non-transmit beat");

  a_status_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != sdspi_pkg::ST_OK |-> kind_o == sdspi_pkg::KIND_DONE)
    else $error("status on non-done beat");

  a_rd_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rd_data_o != 8'd0 |-> kind_o == sdspi_pkg::KIND_RD)
    else $error("read data on non-read beat");

endmodule

bind sd_card_spi_host_engine_core sdspi_checker u_sdspi_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
  .kind_o(kind_o), .cs_active_o(cs_active_o), .rd_data_o(rd_data_o),
  .status_o(status_o), .tx_byte_o(tx_byte_o)
);

[tb/sv/tb_sd_card_spi_host_engine_core.sv]
// Self-checking testbench for sd_card_spi_host_engine_core: a card responder
// drives init, block read and block write sequences plus noise, and a
// scoreboard class predicts every result beat. Depends on sdspi_pkg.
`timescale 1ns / 1ps
module tb_sd_card_spi_host_engine_core;
  import sdspi_pkg::*;

  localparam int unsigned BLOCK_BYTES = 512;
  localparam int STALL_LIMIT = 4000;

  class engine_tracker;
    cfg_t         cfg;
    sdspi_phase_e phase;
    int           byte_cnt, poll_cnt, attempts, blocks_left, polls_done;
    logic [31:0]  cmd_addr;
    bit           blk_addr, v2, fast;
    logic [2:0]   seq_op;
    logic [7:0]   cmd;
    beat_t        expected_beats[$];
    beat_t        step_beats[$];
    int           errors, beats_checked;

    function new();
      cfg = '{init_attempts: 4'd10, idle_poll_limit: 12'd1000, response_polls: 4'd10};
      phase = PH_IDLE;
      byte_cnt = 0; poll_cnt = 0; attempts = 0; blocks_left = 0; polls_done = 0;
      cmd_addr = '0; blk_addr = 0; v2 = 0; fast = 0; seq_op = OP_INIT; cmd = '0;
      errors = 0; beats_checked = 0;
    endfunction

    function void emit(logic [1:0] kind, logic [7:0] txb, logic [7:0] rd, logic [2:0] st,
                       logic [7:0] r1);
      beat_t b;
      if (step_beats.size() >= 2) return;
      b.res.kind = kind;
      b.res.tx = txb;
      b.res.cs = (kind == KIND_TX) && (phase != PH_INIT_DUMMY);
      b.res.rd = rd;
      b.res.st = st;
      b.res.r1 = r1;
      b.res.fast = fast;
      b.last = 1'b0;
      step_beats.push_back(b);
    endfunction

    function void send_byte(logic [7:0] b);
      emit(KIND_TX, b, 8'h00, ST_OK, 8'h00);
    endfunction

    function void complete(logic [2:0] st, logic [7:0] r1);
      phase = PH_IDLE;
      emit(KIND_DONE, 8'h00, 8'h00, st, r1);
    endfunction

    function void move(sdspi_phase_e ph, logic [7:0] b);
      phase = ph;
      send_byte(b);
    endfunction

    function logic [7:0] frame_byte(int i);
      if (i == 0) return cmd;
      if (i < 5) return cmd_addr[8*(4-i) +: 8];
      if (cmd == C_GO_IDLE) return CRC_GO_IDLE;
      if (cmd == C_IF_COND) return CRC_IF_COND;
      return BYTE_IDLE;
    endfunction

    function void begin_cmd(logic [7:0] code, logic [31:0] arg);
      cmd = code;
      cmd_addr = arg;
      byte_cnt = 0;
      move(PH_CMD, code);
    endfunction

    function void begin_attempt();
      fast = 0;
      byte_cnt = 0;
      move(PH_INIT_DUMMY, BYTE_IDLE);
    endfunction

    function void attempt_lost(logic [2:0] st);
      if (attempts < 15) attempts++;
      if (attempts >= cfg.init_attempts) complete(st, 8'h00);
      else begin_attempt();
    endfunction

    function void after_reply(logic [7:0] r);
      case (cmd)
        C_GO_IDLE: begin
          if (r == 8'h01) move(PH_AFTER_IDLE, BYTE_IDLE);
          else if (poll_cnt > cfg.idle_poll_limit) attempt_lost(ST_IDLE_TO);
          else begin
            poll_cnt++;
            begin_cmd(C_GO_IDLE, 32'h0);
          end
        end
        C_IF_COND: begin
          v2 = (r == 8'h01);
          if (v2) byte_cnt = 5;
          else begin
            byte_cnt = 1;
            blk_addr = 0;
          end
          move(PH_SKIP_IF, BYTE_IDLE);
        end
        C_OP_COND: move(r == 8'h00 ? PH_AFTER_OP : PH_RETRY_OP, BYTE_IDLE);
        C_READ_OCR: move(r == 8'h00 ? PH_OCR : PH_FINAL, BYTE_IDLE);
        C_RD_ONE, C_RD_MANY: begin
          if (r != 8'h00) complete(ST_CMD_REJ, r);
          else move(PH_TOKEN, BYTE_IDLE);
        end
        C_WR_ONE: begin
          if (r != 8'h00) complete(ST_CMD_REJ, r);
          else move(PH_WR_TOKEN, TOK_START);
        end
        C_WR_MANY: begin
          if (r > 8'h01) complete(ST_CMD_REJ, r);
          else move(PH_READY_BLOCK, BYTE_IDLE);
        end
        default: move(PH_PAD, BYTE_IDLE);
      endcase
    endfunction

    function void need_data();
      phase = PH_WR_NEED;
      emit(KIND_NEED, 8'h00, 8'h00, ST_OK, 8'h00);
    endfunction

    function logic [7:0] data_cmd();
      case (seq_op)
        OP_RD_ONE:  return C_RD_ONE;
        OP_WR_ONE:  return C_WR_ONE;
        OP_RD_MANY: return C_RD_MANY;
        default:    return C_WR_MANY;
      endcase
    endfunction

    function void on_card_byte(logic [7:0] rx);
      int lim;
      case (phase)
        PH_INIT_DUMMY: begin
          byte_cnt++;
          if (byte_cnt < DUMMY_BYTES) send_byte(BYTE_IDLE);
          else begin
            poll_cnt = 0;
            begin_cmd(C_GO_IDLE, 32'h0);
          end
        end
        PH_CMD: begin
          byte_cnt++;
          if (byte_cnt < 6) send_byte(frame_byte(byte_cnt));
          else if (cmd == C_STOP) move(PH_STUFF, BYTE_IDLE);
          else begin
            polls_done = 0;
            move(PH_POLL, BYTE_IDLE);
          end
        end
        PH_STUFF: begin
          polls_done = 0;
          move(PH_POLL, BYTE_IDLE);
        end
        PH_POLL: begin
          lim = cfg.response_polls == 0 ? 16 : cfg.response_polls;
          polls_done++;
          if (rx[7] && polls_done < lim) send_byte(BYTE_IDLE);
          else after_reply(rx);
        end
        PH_AFTER_IDLE: begin_cmd(C_IF_COND, 32'h1AA);
        PH_SKIP_IF: begin
          if (byte_cnt > 0) byte_cnt--;
          if (byte_cnt > 0) send_byte(BYTE_IDLE);
          else begin
            poll_cnt = 0;
            begin_cmd(C_OP_COND, v2 ? 32'h4000_0000 : 32'h0);
          end
        end
        PH_RETRY_OP: begin
          if (poll_cnt > cfg.idle_poll_limit) attempt_lost(ST_READY_TO);
          else begin
            poll_cnt++;
            begin_cmd(C_OP_COND, cmd_addr);
          end
        end
        PH_AFTER_OP: begin
          if (v2) begin_cmd(C_READ_OCR, 32'h0);
          else move(PH_FINAL, BYTE_IDLE);
        end
        PH_OCR: begin
          blk_addr = rx[6];
          byte_cnt = 4;
          move(PH_SKIP_OCR, BYTE_IDLE);
        end
        PH_SKIP_OCR: begin
          if (byte_cnt > 0) byte_cnt--;
          move(byte_cnt > 0 ? PH_SKIP_OCR : PH_FINAL, BYTE_IDLE);
        end
        PH_FINAL: begin
          fast = 1;
          complete(ST_OK, 8'h00);
        end
        PH_READY_CMD: begin
          if (rx == 8'h00) send_byte(BYTE_IDLE);
          else begin_cmd(data_cmd(), cmd_addr);
        end
        PH_READY_STOP: begin
          if (rx == 8'h00) send_byte(BYTE_IDLE);
          else begin_cmd(C_STOP, 32'h0);
        end
        PH_READY_BLOCK: begin
          if (rx == 8'h00) send_byte(BYTE_IDLE);
          else move(PH_WR_TOKEN, TOK_MULTI);
        end
        PH_READY_END: begin
          if (rx == 8'h00) send_byte(BYTE_IDLE);
          else move(PH_WR_STOP, TOK_STOP);
        end
        PH_TOKEN: begin
          if (rx == TOK_START) begin
            byte_cnt = 0;
            move(PH_RD_DATA, BYTE_IDLE);
          end else send_byte(BYTE_IDLE);
        end
        PH_RD_DATA: begin
          emit(KIND_RD, 8'h00, rx, ST_OK, 8'h00);
          byte_cnt++;
          if (byte_cnt >= BLOCK_BYTES) begin
            byte_cnt = 0;
            phase = PH_RD_CRC;
          end
          send_byte(BYTE_IDLE);
        end
        PH_RD_CRC: begin
          byte_cnt++;
          if (byte_cnt < 2) send_byte(BYTE_IDLE);
          else begin
            if (blocks_left > 0) blocks_left--;
            if (blocks_left > 0) move(PH_TOKEN, BYTE_IDLE);
            else if (seq_op == OP_RD_MANY) move(PH_READY_STOP, BYTE_IDLE);
            else complete(ST_OK, 8'h00);
          end
        end
        PH_WR_TOKEN: begin
          byte_cnt = 0;
          need_data();
        end
        PH_WR_DATA: begin
          byte_cnt++;
          if (byte_cnt < BLOCK_BYTES) need_data();
          else begin
            byte_cnt = 0;
            move(PH_WR_CRC, BYTE_IDLE);
          end
        end
        PH_WR_CRC: begin
          byte_cnt++;
          move(byte_cnt < 2 ? PH_WR_CRC : PH_WR_RESP, BYTE_IDLE);
        end
        PH_WR_RESP: begin
          if (rx[4:0] != DRESP_OK[4:0]) complete(ST_DATA_REJ, 8'h00);
          else begin
            if (blocks_left > 0) blocks_left--;
            if (blocks_left > 0) move(PH_READY_BLOCK, BYTE_IDLE);
            else if (seq_op == OP_WR_MANY) move(PH_READY_END, BYTE_IDLE);
            else complete(ST_OK, 8'h00);
          end
        end
        PH_WR_STOP: move(PH_PAD, BYTE_IDLE);
        PH_PAD: complete(ST_OK, 8'h00);
        default: ;
      endcase
    endfunction

    function void on_request(logic [2:0] op, logic [31:0] addr, logic [7:0] cnt);
      if (op == OP_INIT) begin
        seq_op = OP_INIT;
        attempts = 0;
        if (cfg.init_attempts == 0) complete(ST_IDLE_TO, 8'h00);
        else begin_attempt();
        return;
      end
      if (op > OP_WR_MANY) begin
        complete(ST_CMD_REJ, 8'h00);
        return;
      end
      seq_op = op;
      cmd_addr = blk_addr ? addr : addr * 32'(BLOCK_BYTES);
      if (op == OP_RD_MANY || op == OP_WR_MANY) blocks_left = cnt == 0 ? 256 : cnt;
      else blocks_left = 1;
      move(PH_READY_CMD, BYTE_IDLE);
    endfunction

    function void note_beat(logic [1:0] act, logic [2:0] op, logic [31:0] addr,
                            logic [7:0] cnt, logic [7:0] rx, logic [7:0] wr);
      beat_t b;
      step_beats.delete();
      case (act)
        ACT_REQUEST: if (phase == PH_IDLE) on_request(op, addr, cnt);
        ACT_RX:      on_card_byte(rx);
        ACT_WDATA:   if (phase == PH_WR_NEED) move(PH_WR_DATA, wr);
        default: ;
      endcase
      if (step_beats.size() > 0) step_beats[step_beats.size()-1].last = 1'b1;
      foreach (step_beats[i]) begin
        b = step_beats[i];
        expected_beats.push_back(b);
      end
    endfunction

    function void check_result(beat_t got);
      beat_t exp_b;
      beats_checked++;
      if (expected_beats.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h", got);
        return;
      end
      exp_b = expected_beats.pop_front();
      if (got !== exp_b) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp kind %0d tx %h cs %0d rd %h st %0d r1 %h fast %0d last %0d",
                   exp_b.res.kind, exp_b.res.tx, exp_b.res.cs, exp_b.res.rd, exp_b.res.st,
                   exp_b.res.r1, exp_b.res.fast, exp_b.last,
                   " / got kind %0d tx %h cs %0d rd %h st %0d r1 %h fast %0d last %0d",
                   got.res.kind, got.res.tx, got.res.cs, got.res.rd, got.res.st,
                   got.res.r1, got.res.fast, got.last);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [11:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  action_i = '0;
  logic [2:0]  op_i = '0;
  logic [31:0] block_addr_i = '0;
  logic [7:0]  block_count_i = '0;
  logic [7:0]  rx_byte_i = '0;
  logic [7:0]  wr_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  tx_byte_o;
  logic        cs_active_o;
  logic [7:0]  rd_data_o;
  logic [2:0]  status_o;
  logic [7:0]  r1_value_o;
  logic        fast_clock_o;
  logic        last_o;

  engine_tracker sb = new();
  int  items_sent = 0;
  int  wr_blocks = 0;
  int  xfers_left = 1;
  int  seq_count[8];
  int  quiet_idle_cycles = 0;
  bit  sender_quiet = 0;

  sd_card_spi_host_engine_core dut (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_idle_cycles <= 0;
    else quiet_idle_cycles <= quiet_idle_cycles + 1;
    if (quiet_idle_cycles > STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_beat(logic [1:0] act, logic [2:0] op, logic [31:0] addr,
                           logic [7:0] cnt, logic [7:0] rx, logic [7:0] wr);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    op_i <= op;
    block_addr_i <= addr;
    block_count_i <= cnt;
    rx_byte_i <= rx;
    wr_data_i <= wr;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_beat(act, op, addr, cnt, rx, wr);
    items_sent++;
  endtask

  task automatic drain_and_write(logic [3:0] att, logic [11:0] lim, logic [3:0] polls);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_beats.size() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_ATTEMPTS;
    cfg_data_i <= 12'(att);
    @(posedge clk_i);
    cfg_idx_i <= CFG_IDLE_LIMIT;
    cfg_data_i <= lim;
    @(posedge clk_i);
    cfg_idx_i <= CFG_POLLS;
    cfg_data_i <= 12'(polls);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.cfg = '{init_attempts: att, idle_poll_limit: lim, response_polls: polls};
  endtask

  function automatic logic [7:0] card_byte();
    logic [7:0] b;
    b = 8'($urandom);
    case (sb.phase)
      PH_POLL: begin
        if ($urandom_range(0, 3) == 0) return 8'h80 | b;
        case (sb.cmd)
          C_GO_IDLE: return ($urandom_range(0, 4) != 0) ? 8'h01 : {1'b0, b[6:0]};
          C_IF_COND: return $urandom_range(0, 1) ? 8'h01 : 8'h05;
          C_OP_COND: return $urandom_range(0, 1) ? 8'h00 : 8'h01;
          C_RD_ONE, C_RD_MANY, C_WR_ONE, C_WR_MANY: begin
            if (xfers_left == 0 || $urandom_range(0, 9) == 0)
              return 8'($urandom_range(2, 127));
            xfers_left--;
            return (sb.cmd == C_WR_MANY && b[0]) ? 8'h01 : 8'h00;
          end
          default: return ($urandom_range(0, 9) != 0) ? 8'h00 : 8'($urandom_range(1, 127));
        endcase
      end
      PH_READY_CMD, PH_READY_STOP, PH_READY_BLOCK, PH_READY_END:
        return $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(1, 255));
      PH_TOKEN: return ($urandom_range(0, 2) != 0) ? TOK_START : b;
      PH_WR_RESP: begin
        if (wr_blocks >= 2 || $urandom_range(0, 9) == 0) begin
          if (b[4:0] == DRESP_OK[4:0]) b[0] = 1'b0;
          return b;
        end
        wr_blocks++;
        return {b[7:5], DRESP_OK[4:0]};
      end
      default: return b;
    endcase
  endfunction

  task automatic start_request();
    logic [2:0]  op;
    logic [31:0] addr;
    logic [7:0]  cnt;
    int r;
    r = $urandom_range(0, 19);
    op = r < 4 ? OP_INIT : r < 19 ? 3'($urandom_range(1, 4)) : 3'($urandom_range(5, 7));
    r = $urandom_range(0, 5);
    addr = r == 0 ? 32'h0 : r == 1 ? 32'hFFFF_FFFF : 32'($urandom);
    cnt = (op == OP_RD_MANY || op == OP_WR_MANY) ? 8'd1 : 8'($urandom);
    wr_blocks = 0;
    sender_quiet = $urandom_range(0, 3) == 0;
    seq_count[op]++;
    send_beat(ACT_REQUEST, op, addr, cnt, 8'($urandom), 8'($urandom));
  endtask

  task automatic run_traffic(int quota);
    int start_items;
    start_items = items_sent;
    while (items_sent - start_items < quota || sb.phase != PH_IDLE) begin
      if ($urandom_range(0, 24) == 0 && sb.phase != PH_IDLE)
        send_beat(2'($urandom), 3'($urandom), 32'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom));
      else if (sb.phase == PH_IDLE) start_request();
      else if (sb.phase == PH_WR_NEED)
        send_beat(ACT_WDATA, 3'($urandom), 32'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom));
      else
        send_beat(ACT_RX, 3'($urandom), 32'($urandom), 8'($urandom), card_byte(),
                  8'($urandom));
    end
  endtask

  initial begin
    int gap;
    int taken;
    beat_t got;
    taken = 0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (taken == 200) gap = 300;
      else if ((taken / 64) % 3 == 0) gap = 0;
      else gap = $urandom_range(0, 14);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      got.res.kind = kind_o;
      got.res.tx = tx_byte_o;
      got.res.cs = cs_active_o;
      got.res.rd = rd_data_o;
      got.res.st = status_o;
      got.res.r1 = r1_value_o;
      got.res.fast = fast_clock_o;
      got.last = last_o;
      sb.check_result(got);
      taken++;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_beat(ACT_NONE, 3'h7, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF);
    send_beat(ACT_RX, OP_INIT, 32'h0, 8'h00, 8'h00, 8'h00);
    send_beat(ACT_WDATA, OP_INIT, 32'h0, 8'h00, 8'h00, 8'hFF);
    send_beat(ACT_REQUEST, 3'd5, 32'h0, 8'h00, 8'h00, 8'h00);
    send_beat(ACT_REQUEST, 3'd6, 32'hFFFF_FFFF, 8'hFF, 8'h00, 8'h00);
    send_beat(ACT_REQUEST, 3'd7, 32'h8000_0001, 8'h80, 8'h00, 8'h00);
    send_beat(ACT_REQUEST, OP_INIT, 32'h0, 8'h00, 8'h00, 8'h00);
    send_beat(ACT_REQUEST, OP_RD_ONE, 32'hFFFF_FFFF, 8'hFF, 8'h00, 8'h00);
    seq_count[OP_INIT]++;
    run_traffic(70);
    drain_and_write(4'd1, 12'd1, 4'd1);
    run_traffic(70);
    drain_and_write(4'd15, 12'd4095, 4'd15);
    run_traffic(70);
    drain_and_write(4'd0, 12'd0, 4'd0);
    run_traffic(70);
    drain_and_write(4'd3, 12'd20, 4'd4);
    run_traffic(70);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_beats.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("sent %0d input beats and checked %0d result beats over five register settings",
             items_sent, sb.beats_checked);
    $display("sequences: init %0d, rd1 %0d, wr1 %0d, rdN %0d, wrN %0d, bad op %0d",
             seq_count[0], seq_count[1], seq_count[2], seq_count[3], seq_count[4],
             seq_count[5] + seq_count[6] + seq_count[7]);
    if (sb.errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
